/* hdl/powsrv_pkg.sv */
// ----------------------------------------------------------------------------
// powsrv_pkg: shared types and constants of the offset window servo
// widths, operation and status codes, controller/datapath command bundle
// ----------------------------------------------------------------------------
`default_nettype none

package powsrv_pkg;

  localparam int unsigned MaxWindow = 16;
  localparam int unsigned IdxW      = $clog2(MaxWindow);
  localparam int unsigned CntW      = $clog2(MaxWindow + 1);
  localparam int unsigned DivCntW   = 7;

  localparam logic [1:0] OpObserve = 2'd0;
  localparam logic [1:0] OpQuery   = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StRejected = 2'd1;
  localparam logic [1:0] StRearmed  = 2'd2;
  localparam logic [1:0] StNoSample = 2'd3;

  localparam logic [1:0] RegWindowLength = 2'd0;
  localparam logic [1:0] RegOutlierGuard = 2'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic          load;       // capture input item, compute delay and offset
    logic          scan_clr;   // clear accumulators before a window walk
    logic          scan_en;    // accumulate the entry at scan_idx
    logic [IdxW-1:0] scan_idx;
    logic          div_start;  // start both mean divisions
    logic          write_en;   // write sample into the window
    logic [IdxW-1:0] write_idx;
    logic          zero_means; // unlocked: means are zero
    logic          out_load;   // load output register
  } powsrv_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic outlier;   // last sample deviates beyond spread plus guard
  } powsrv_sts_t;

endpackage

`default_nettype wire

/* hdl/powsrv_div.sv */
// ----------------------------------------------------------------------------
// powsrv_div: serial signed divider
// one quotient bit per cycle, truncates toward zero, divisor 1..16
// ----------------------------------------------------------------------------
`default_nettype none

module powsrv_div
  import powsrv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [63:0]     dividend_i,
  input  wire logic [CntW-1:0] divisor_i,
  output logic                 busy_o,
  output logic [63:0]          quotient_o
);

  logic [63:0]        quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    den_q;
  logic               neg_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic [CntW:0]      trial;

  always_comb begin
    trial = {rem_q, quo_q[63]};
    quo_d = {quo_q[62:0], 1'b0};
    rem_d = trial[CntW-1:0];
    if (trial >= {1'b0, den_q}) begin
      rem_d    = CntW'(trial - {1'b0, den_q});
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(64);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[63];
      quo_q <= dividend_i[63] ? 64'(-dividend_i) : dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? 64'(-quo_q) : quo_q;

endmodule

`default_nettype wire

/* hdl/powsrv_datapath.sv */
// ----------------------------------------------------------------------------
// powsrv_datapath: sample arithmetic, window store and statistics
// window memories, sum/min/max accumulation, mean division, outlier test
// ----------------------------------------------------------------------------
`default_nettype none

module powsrv_datapath
  import powsrv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire powsrv_cmd_t     cmd_i,
  output powsrv_sts_t          sts_o,
  input  wire logic [CntW-1:0] fill_i,
  input  wire logic [39:0]     guard_i,
  input  wire logic [63:0]     t1_i,
  input  wire logic [63:0]     t2_i,
  input  wire logic [63:0]     t3_i,
  input  wire logic [63:0]     t4_i,
  input  wire logic [63:0]     local_i,
  output logic [63:0]          mean_off_o,
  output logic [63:0]          mean_dly_o,
  output logic [63:0]          master_o
);

  logic [63:0] off_mem [MaxWindow];
  logic [63:0] dly_mem [MaxWindow];

  logic [63:0] d21_q, d43_q, loc_q, off_q, dly_q;
  logic        calc_q;
  logic [63:0] sum_dly, dly_calc;
  logic [63:0] rd_off_q, rd_dly_q;
  logic        rd_v_q, rd_first_q;
  logic [63:0] base_off_q, base_dly_q, acc_off_q, acc_dly_q, lo_q, hi_q;
  logic [63:0] qoff, qdly, mean_off, mean_dly, dev, abs_dev, lim;
  logic        div_bsy_o, div_bsy_d;

  assign sum_dly  = d21_q + d43_q;
  assign dly_calc = 64'($signed(sum_dly + {63'd0, sum_dly[63]}) >>> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_q <= 1'b0;
      rd_v_q <= 1'b0;
    end else begin
      calc_q <= cmd_i.load;
      rd_v_q <= cmd_i.scan_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d21_q <= t2_i - t1_i;
      d43_q <= t4_i - t3_i;
      loc_q <= local_i;
    end
    if (calc_q) begin
      dly_q <= {dly_calc[63], dly_calc[62:0]};
      off_q <= d21_q - {dly_calc[63], dly_calc[62:0]};
    end
    if (cmd_i.write_en) begin
      off_mem[cmd_i.write_idx] <= off_q;
      dly_mem[cmd_i.write_idx] <= dly_q;
    end
    rd_off_q <= off_mem[cmd_i.scan_idx];
    rd_dly_q <= dly_mem[cmd_i.scan_idx];
    rd_first_q <= (cmd_i.scan_idx == '0);
  end

  // walk: registered read, then accumulate relative to entry zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      acc_off_q <= '0;
      acc_dly_q <= '0;
    end else if (rd_v_q) begin
      if (rd_first_q) begin
        base_off_q <= rd_off_q;
        base_dly_q <= rd_dly_q;
        lo_q       <= rd_off_q;
        hi_q       <= rd_off_q;
      end else begin
        acc_off_q <= acc_off_q + (rd_off_q - base_off_q);
        acc_dly_q <= acc_dly_q + (rd_dly_q - base_dly_q);
        if ($signed(rd_off_q) < $signed(lo_q)) lo_q <= rd_off_q;
        if ($signed(rd_off_q) > $signed(hi_q)) hi_q <= rd_off_q;
      end
    end
  end

  powsrv_div u_div_off (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(acc_off_q),
    .divisor_i(fill_i), .busy_o(div_bsy_o), .quotient_o(qoff)
  );
  powsrv_div u_div_dly (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(acc_dly_q),
    .divisor_i(fill_i), .busy_o(div_bsy_d), .quotient_o(qdly)
  );

  assign mean_off = base_off_q + qoff;
  assign mean_dly = base_dly_q + qdly;
  assign dev      = off_q - mean_off;
  assign abs_dev  = dev[63] ? 64'(-dev) : dev;
  assign lim      = (hi_q - lo_q) + {24'd0, guard_i};

  assign sts_o.div_busy = div_bsy_o | div_bsy_d;
  assign sts_o.outlier  = $signed(abs_dev) > $signed(lim);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_off_o <= cmd_i.zero_means ? '0 : mean_off;
      mean_dly_o <= cmd_i.zero_means ? '0 : mean_dly;
      master_o   <= loc_q - (cmd_i.zero_means ? 64'd0 : mean_off);
    end
  end

endmodule

`default_nettype wire

/* hdl/powsrv_ctrl.sv */
// ----------------------------------------------------------------------------
// powsrv_ctrl: servo sequencer
// window bookkeeping, lock and reject counting, walk and divide sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module powsrv_ctrl
  import powsrv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      op_i,
  input  wire logic [4:0]      wlen_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 locked_o,
  output logic [1:0]           status_o,
  output powsrv_cmd_t          cmd_o,
  input  wire powsrv_sts_t     sts_i,
  output logic [CntW-1:0]      fill_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_SCAN, S_DIV, S_DECIDE, S_MEAN, S_OUT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] fill_q, len_q, run_q, scan_q;
  logic [IdxW-1:0] slot_q;
  logic            lock_q, check_q, valid_q;
  logic [1:0]      op_q, status_q;
  logic [1:0]      drain_q;
  logic [CntW-1:0] len_eff;
  logic            accept;

  always_comb begin
    if (wlen_i == '0) len_eff = CntW'(1);
    else if (wlen_i > 5'(MaxWindow)) len_eff = CntW'(MaxWindow);
    else len_eff = CntW'(wlen_i);
  end

  assign in_ready_o  = (state_q == S_IDLE) && !valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign locked_o    = lock_q;
  assign status_o    = status_q;
  assign fill_o      = fill_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load       = accept;
    cmd_o.scan_idx   = scan_q[IdxW-1:0];
    cmd_o.scan_en    = (state_q == S_SCAN) && (scan_q < fill_q);
    cmd_o.scan_clr   = (state_q == S_CALC) || (state_q == S_DECIDE);
    cmd_o.write_idx  = (fill_q < len_q) ? fill_q[IdxW-1:0]
                     : ((CntW'(slot_q) >= fill_q) ? '0 : slot_q);
    cmd_o.write_en   = (state_q == S_DECIDE) && (drain_q == 2'd2);
    cmd_o.div_start  = (state_q == S_DIV);
    cmd_o.out_load   = (state_q == S_OUT);
    cmd_o.zero_means = !lock_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      slot_q  <= '0;
      run_q   <= '0;
      lock_q  <= 1'b0;
      valid_q <= 1'b0;
      check_q <= 1'b0;
      scan_q  <= '0;
      drain_q <= '0;
      len_q   <= '0;
      op_q    <= '0;
      status_q <= StNoSample;
    end else begin
      if (valid_q && out_ready_i) valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= op_i;
            len_q  <= len_eff;
            scan_q <= '0;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (op_q == OpObserve) begin
            check_q <= lock_q && (fill_q >= len_q) && (fill_q != '0);
            state_q <= S_SCAN;
          end else begin
            if (op_q == OpRestart) begin
              fill_q <= '0; slot_q <= '0; run_q <= '0; lock_q <= 1'b0;
            end
            status_q <= StNoSample;
            check_q  <= 1'b0;
            state_q  <= S_SCAN;
          end
          drain_q <= '0;
        end
        S_SCAN: begin
          // after the last read, drain_q holds the walk until the read and accumulate stages drain
          if (scan_q < fill_q) scan_q <= scan_q + 1'b1;
          else if (drain_q == 2'd1) begin
            drain_q <= '0;
            state_q <= S_DIV;
          end else drain_q <= drain_q + 1'b1;
        end
        S_DIV: state_q <= S_MEAN;
        S_MEAN: begin
          if (!sts_i.div_busy) begin
            if (op_q == OpObserve && check_q) begin
              check_q <= 1'b0;
              state_q <= S_DECIDE;
            end else if (op_q == OpObserve) begin
              // push without test, then rescan for the reported means
              op_q     <= OpQuery;
              status_q <= (status_q == StRearmed) ? StRearmed : StAccepted;
              state_q  <= S_DECIDE;
              drain_q  <= 2'd2;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_DECIDE: begin
          scan_q <= '0;
          if (drain_q == 2'd2) begin
            // write sample
            if (fill_q < len_q) fill_q <= fill_q + 1'b1;
            else slot_q <= IdxW'((CntW'(cmd_o.write_idx) + 1'b1 >= fill_q) ? '0
                                 : cmd_o.write_idx + 1'b1);
            if ((fill_q < len_q ? fill_q + 1'b1 : fill_q) >= len_q) lock_q <= 1'b1;
            drain_q <= '0;
            state_q <= S_SCAN;
          end else if (sts_i.outlier) begin
            if (run_q + 1'b1 < len_q) begin
              run_q    <= run_q + 1'b1;
              status_q <= StRejected;
              op_q     <= OpQuery;
              state_q  <= S_SCAN;
            end else begin
              fill_q <= '0; slot_q <= '0; run_q <= '0;
              status_q <= StRearmed;
              state_q  <= S_MEAN;
            end
          end else begin
            run_q    <= '0;
            status_q <= StAccepted;
            state_q  <= S_MEAN;
          end
        end
        S_OUT: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_CALC && op_q == OpObserve) status_q <= StAccepted;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxWindow)) else $error("fill count overflow");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> valid_q) else $error("result not presented");

endmodule

`default_nettype wire

/* hdl/ptp_offset_window_servo.sv */
// ----------------------------------------------------------------------------
// ptp_offset_window_servo: two-way time transfer offset/delay servo
// moving-average window with lock, outlier rejection and re-arm
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Every pass walks the window one entry
// a cycle through a registered read and then waits on the two serial dividers
// for the means. A query, an invalid exchange or a restart takes one pass; an
// observed exchange takes two passes, whether untested, rejected, tested and
// kept or re-armed. The input is not ready while an item is in work or its
// result waits; after the output transfer the next input can be taken in the
// cycle after. Input tuser carries the operation, output tuser the lock flag
// and sample status. Registers: window_length at 0x0, outlier_guard at 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_offset_window_servo
  import powsrv_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // operation[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  // t1[63:0], t2[127:64], t3[191:128], t4[255:192], local_time[319:256]
  input  wire logic [319:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // is_locked[0], sample_status[2:1]
  output logic [2:0]        m_axis_tuser_o,
  // mean_offset[63:0], mean_path_delay[127:64], master_time[191:128]
  output logic [191:0]      m_axis_tdata_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [4:0]  wlen_q;
  logic [39:0] guard_q;
  powsrv_cmd_t cmd;
  powsrv_sts_t sts;
  logic [CntW-1:0] fill;
  logic [63:0] moff, mdly, mtime;
  logic        locked;
  logic [1:0]  status;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // registers sit 8 bytes apart, so paddr[3] selects
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q  <= 5'd8;
      guard_q <= 40'd1000000;
    end else if (cfg_wr) begin
      if (paddr[3] == RegWindowLength[0]) wlen_q <= pwdata[4:0];
      else guard_q <= pwdata[39:0];
    end
  end

  assign prdata = (paddr[3] == RegOutlierGuard[0]) ? {24'd0, guard_q} : {59'd0, wlen_q};

  // controller: handshakes, window bookkeeping, sequencing
  powsrv_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .op_i(s_axis_tuser_i), .wlen_i(wlen_q),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .locked_o(locked), .status_o(status), .cmd_o(cmd), .sts_i(sts), .fill_o(fill)
  );

  // datapath: timestamp arithmetic, window store, means and outlier test
  powsrv_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .fill_i(fill), .guard_i(guard_q),
    .t1_i(s_axis_tdata_i[63:0]), .t2_i(s_axis_tdata_i[127:64]),
    .t3_i(s_axis_tdata_i[191:128]), .t4_i(s_axis_tdata_i[255:192]),
    .local_i(s_axis_tdata_i[319:256]),
    .mean_off_o(moff), .mean_dly_o(mdly), .master_o(mtime)
  );

  // lock and status registers hold while the result waits
  assign m_axis_tuser_o = {status, locked};
  assign m_axis_tdata_o = {mtime, mdly, moff};

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the offset window servo
// drives ptp exchanges, queries and restarts through the input stream, writes
// window length and guard over apb while idle, and checks every output
// transfer field by field against an in-bench window predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import powsrv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  // one expected output transfer
  typedef struct packed {
    logic        locked;
    logic [63:0] moff;
    logic [63:0] mdly;
    logic [63:0] mtime;
    logic [1:0]  status;
  } servo_out_t;

  // one row of the directed table: chk set means exp is typed in
  typedef struct {
    logic [1:0]  op;
    logic [63:0] t1, t2, t3, t4, lt;
    bit          chk;
    servo_out_t  exp;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [1:0]   s_axis_tuser_i = '0;
  logic [319:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [2:0]   m_axis_tuser_o;
  logic [191:0] m_axis_tdata_o;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  ptp_offset_window_servo dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [63:0] win_off [MaxWindow];
  logic [63:0] win_dly [MaxWindow];
  int unsigned fill_cnt, wr_slot, rej_run;
  bit          locked_q;
  logic [4:0]  cfg_len;
  logic [39:0] cfg_guard;

  servo_out_t  pending_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          rx_stall_en = 1'b1;
  bit          tx_gap_en = 1'b1;
  int unsigned rx_idle = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned len_eff();
    if (cfg_len == 0) return 1;
    if (cfg_len > MaxWindow) return MaxWindow;
    return cfg_len;
  endfunction

  // signed divide truncating toward zero
  function automatic logic [63:0] div_trunc(logic [63:0] v, logic [63:0] d);
    if (d == 0) return '0;
    if (v[63]) return -((-v) / d);
    return v / d;
  endfunction

  function automatic logic [63:0] win_avg(bit use_dly);
    logic [63:0] base, acc, e;
    acc = '0;
    if (fill_cnt == 0) return '0;
    base = use_dly ? win_dly[0] : win_off[0];
    for (int i = 0; i < fill_cnt; i++) begin
      e = use_dly ? win_dly[i] : win_off[i];
      acc += e - base;
    end
    return base + div_trunc(acc, 64'(fill_cnt));
  endfunction

  function automatic void win_push(logic [63:0] off, logic [63:0] dly);
    int unsigned n;
    n = len_eff();
    if (fill_cnt < n) begin
      win_off[fill_cnt] = off;
      win_dly[fill_cnt] = dly;
      fill_cnt++;
    end else begin
      if (wr_slot >= fill_cnt) wr_slot = 0;
      win_off[wr_slot] = off;
      win_dly[wr_slot] = dly;
      wr_slot = (wr_slot + 1) % fill_cnt;
    end
    if (fill_cnt >= n) locked_q = 1'b1;
  endfunction

  // exchange: delay and offset, outlier test, window update
  function automatic logic [1:0] exchange_observe(logic [63:0] t1, t2, t3, t4);
    logic [63:0] d21, dly, off, avg, dev, lo, hi;
    int unsigned n;
    d21 = t2 - t1;
    dly = div_trunc(d21 + (t4 - t3), 64'd2);
    off = d21 - dly;
    n = len_eff();
    if (locked_q && fill_cnt >= n && fill_cnt > 0) begin
      avg = win_avg(1'b0);
      dev = off - avg;
      if (dev[63]) dev = -dev;
      lo = win_off[0];
      hi = lo;
      for (int i = 0; i < fill_cnt; i++) begin
        if ($signed(lo) > $signed(win_off[i])) lo = win_off[i];
        if ($signed(win_off[i]) > $signed(hi)) hi = win_off[i];
      end
      if ($signed(dev) > $signed((hi - lo) + 64'(cfg_guard))) begin
        rej_run++;
        if (rej_run < n) return StRejected;
        fill_cnt = 0;
        wr_slot = 0;
        rej_run = 0;
        win_push(off, dly);
        return StRearmed;
      end
      rej_run = 0;
    end
    win_push(off, dly);
    return StAccepted;
  endfunction

  function automatic servo_out_t servo_predict(logic [1:0] op,
                                               logic [63:0] t1, t2, t3, t4, lt);
    servo_out_t r;
    r.status = StNoSample;
    if (op == OpObserve) begin
      r.status = exchange_observe(t1, t2, t3, t4);
    end else if (op == OpRestart) begin
      fill_cnt = 0;
      wr_slot = 0;
      rej_run = 0;
      locked_q = 1'b0;
    end
    r.locked = locked_q;
    r.moff = locked_q ? win_avg(1'b0) : '0;
    r.mdly = locked_q ? win_avg(1'b1) : '0;
    r.mtime = lt - r.moff;
    return r;
  endfunction

  // output side: random stall bursts on tready, compare with the oldest expectation
  always @(negedge clk_i) begin
    if (rx_stall_en && rx_idle == 0 && $urandom_range(0, 7) == 0)
      rx_idle = $urandom_range(1, 10);
    if (rx_idle != 0) begin
      m_axis_tready_i <= 1'b0;
      rx_idle--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    servo_out_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.locked = m_axis_tuser_o[0];
      got.status = m_axis_tuser_o[2:1];
      got.moff   = m_axis_tdata_o[63:0];
      got.mdly   = m_axis_tdata_o[127:64];
      got.mtime  = m_axis_tdata_o[191:128];
      if (pending_q.size() == 0) begin
        $error("output transfer with no expectation waiting");
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.locked !== want.locked) begin
          $error("is_locked exp %0d got %0d", want.locked, got.locked);
          fail_cnt++;
        end
        if (got.moff !== want.moff) begin
          $error("mean_offset exp %0h got %0h", want.moff, got.moff);
          fail_cnt++;
        end
        if (got.mdly !== want.mdly) begin
          $error("mean_path_delay exp %0h got %0h", want.mdly, got.mdly);
          fail_cnt++;
        end
        if (got.mtime !== want.mtime) begin
          $error("master_time exp %0h got %0h", want.mtime, got.mtime);
          fail_cnt++;
        end
        if (got.status !== want.status) begin
          $error("sample_status exp %0d got %0d", want.status, got.status);
          fail_cnt++;
        end
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 3;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegWindowLength) cfg_len = val[4:0];
    else cfg_guard = val[39:0];
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_item(logic [1:0] op, logic [63:0] t1, t2, t3, t4, lt,
                           bit chk, servo_out_t exp);
    servo_out_t p;
    if (tx_gap_en && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {lt, t4, t3, t2, t1};
    p = servo_predict(op, t1, t2, t3, t4, lt);
    if (chk && p !== exp) begin
      $error("table row disagrees with predictor: exp %0h pred %0h", exp, p);
      fail_cnt++;
    end
    pending_q.insert(pending_q.size(), p);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // exchange near a level: small random delay and offset jitter
  task automatic send_near(logic [63:0] lvl, int unsigned jit, logic [63:0] lt);
    logic [63:0] t1, t3, dl;
    t1 = rnd64();
    t3 = rnd64();
    dl = 64'($urandom_range(0, 2000));
    send_item(OpObserve, t1, t1 + dl + lvl + 64'($urandom_range(0, jit)),
              t3, t3 + dl - lvl, lt, 1'b0, '0);
  endtask

  initial begin
    stim_row_t tbl[$];
    logic [63:0] lvl;
    int unsigned k;
    logic [63:0] mx, mn;
    mx = 64'h7fff_ffff_ffff_ffff;
    mn = 64'h8000_0000_0000_0000;
    cfg_len = 5'd8;
    cfg_guard = 40'd1000000;
    fill_cnt = 0;
    wr_slot = 0;
    rej_run = 0;
    locked_q = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // after reset: queries and restarts give zero means, status no sample
    tbl.insert(tbl.size(), '{OpQuery, 0, 0, 0, 0, 64'd5, 1, '{0, 0, 0, 64'd5, StNoSample}});
    tbl.insert(tbl.size(), '{2'd3, mx, mn, mx, mn, mx, 1, '{0, 0, 0, mx, StNoSample}});
    tbl.insert(tbl.size(), '{OpRestart, mn, mx, mn, mx, mn, 1, '{0, 0, 0, mn, StNoSample}});
    tbl.insert(tbl.size(), '{OpQuery, rnd64(), rnd64(), rnd64(), rnd64(), '1, 1,
                             '{0, 0, 0, '1, StNoSample}});
    // unlocked observe: accepted, means still zero
    tbl.insert(tbl.size(), '{OpObserve, 0, 100, 0, 100, 64'd7, 1,
                             '{0, 0, 0, 64'd7, StAccepted}});
    // wrapping extremes of the timestamps
    tbl.insert(tbl.size(), '{OpObserve, mn, mx, mn, mx, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, mx, mn, mx, mn, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, 0, mx, mx, 0, mn, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, '1, 0, 0, 64'd2, mx, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, 0, 64'd3, 0, 0, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, 0, -64'sd3, 0, 0, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, 0, 64'd1, 0, 0, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpQuery, 0, 0, 0, 0, mx, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, 0, mn, 0, 0, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpObserve, 0, 64'd1000, 0, 64'd10, 0, 0, '0});
    tbl.insert(tbl.size(), '{OpRestart, 0, 0, 0, 0, 64'd9, 1,
                             '{0, 0, 0, 64'd9, StNoSample}});
    foreach (tbl[i])
      send_item(tbl[i].op, tbl[i].t1, tbl[i].t2, tbl[i].t3, tbl[i].t4, tbl[i].lt,
                tbl[i].chk, tbl[i].exp);
    wait_drained();

    // random phases over several settings; length extremes incl. 0 and above max
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin apb_write(RegWindowLength, 64'd1); apb_write(RegOutlierGuard, 0); end
        1: begin apb_write(RegWindowLength, 64'd16); apb_write(RegOutlierGuard, 64'd500); end
        2: apb_write(RegWindowLength, 64'd3);
        3: begin apb_write(RegWindowLength, 64'd0); apb_write(RegOutlierGuard, '1); end
        4: begin apb_write(RegWindowLength, 64'd31); apb_write(RegOutlierGuard, 64'd100); end
        5: apb_write(RegWindowLength, 64'd2);  // shorter than the filled window
        default: begin
          apb_write(RegWindowLength, 64'($urandom_range(0, 31)));
          apb_write(RegOutlierGuard, {24'd0, 8'($urandom()), 32'($urandom())} >>
                    $urandom_range(0, 39));
        end
      endcase
      if (ph >= 8) begin
        tx_gap_en = 1'b0;
        rx_stall_en = 1'b0;
      end
      lvl = rnd64() >> $urandom_range(0, 63);
      for (int n = 0; n < 40; n++) begin
        k = $urandom_range(0, 19);
        if (k < 13) begin
          send_near(lvl, 300, rnd64());
        end else if (k < 16) begin
          // spike, and sometimes a run of them to force a re-arm
          lvl = (k == 15) ? rnd64() : lvl;
          send_near(lvl + 64'($urandom_range(0, 1 << 30)) * 64'd4096, 300, rnd64());
        end else if (k < 18) begin
          send_item(OpQuery, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 0, '0);
        end else if (k == 18) begin
          send_item(2'd3, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 0, '0);
        end else if ($urandom_range(0, 2) == 0) begin
          send_item(OpRestart, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 0, '0);
        end else begin
          send_item(OpObserve, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 0, '0);
        end
      end
      // sender holds off until every expected result is back
      wait_drained();
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/powsrv_pkg.sv
hdl/powsrv_div.sv
hdl/powsrv_datapath.sv
hdl/powsrv_ctrl.sv
hdl/ptp_offset_window_servo.sv
bench/tb_top.sv
